// File: sv/gbf_pkg.sv
// ============================================================================
// gbf_pkg: shared types and constants
// Request and response structs, opcodes and sizes for the bridge finder.
// ============================================================================
package gbf_pkg;

   localparam int unsigned MaxVertices = 64;
   localparam int unsigned MaxEdges    = 256;
   localparam int unsigned VtxW        = $clog2(MaxVertices);
   localparam int unsigned EdgeAw      = $clog2(MaxEdges);
   localparam int unsigned EdgeCntW    = EdgeAw + 1;
   localparam int unsigned CursorW     = EdgeAw + 2;
   localparam int unsigned BrW         = 2 * VtxW;
   localparam int unsigned FrameW      = 2 * VtxW + 1 + CursorW;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_RUN   = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] end_a;
      logic [5:0] end_b;
      logic [6:0] vertex_count;
   } req_type;

   typedef struct packed {
      logic [5:0] bridge_low;
      logic [5:0] bridge_high;
      logic       found;
      logic       last;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic [VtxW-1:0]    vtx;
      logic [VtxW-1:0]    parent;
      logic               has_parent;
      logic [CursorW-1:0] cursor;
   } frame_type;

endpackage

// File: sv/graph_bridge_finder_top.sv
// ============================================================================
// graph_bridge_finder_top: Tarjan bridge finder over a stored multigraph
// Edge store, iterative depth-first search and bridge sort under one sequencer.
// ============================================================================
// Clear and add requests are taken while the block is idle, and it stays ready
// for the next request. A run request starts a depth-first search from vertex
// 0 that walks the whole edge store (two directed slots per edge) once for
// every visited vertex; a tree edge, an already visited neighbor or a finished
// vertex costs extra stack and table memory reads. The bridges are then
// insertion-sorted through the list memory, and one response per bridge is
// emitted (a single not-found response when there is none), each held until
// it is taken. The block accepts no request from the run request until its
// last response is taken. No clearing pass is needed: the visited marks are
// registers set to mark only vertex 0 at the start of each run, and every
// table entry is written before it is read.
module graph_bridge_finder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gbf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gbf_pkg::rsp_type rsp_data
);

   localparam int unsigned VW = gbf_pkg::VtxW;
   localparam int unsigned EA = gbf_pkg::EdgeAw;
   localparam int unsigned CW = gbf_pkg::CursorW;

   typedef enum logic [4:0] {
      ST_IDLE, ST_START, ST_FRAME_RD, ST_FRAME_WAIT, ST_EDGE_WAIT, ST_EDGE,
      ST_NBR_WAIT, ST_NBR, ST_POP_WAIT, ST_POP_LOAD, ST_POP, ST_SORT_I,
      ST_SORT_KEY, ST_SORT_CMP_RD, ST_SORT_CMP, ST_SORT_PUT, ST_EMIT_RD,
      ST_EMIT_WAIT, ST_EMIT
   } state_type;

   state_type state_ff;

   // Control and scalar registers.
   logic [EA:0]     edge_total_ff;
   logic            overflow_ff;
   logic [VW:0]     nvtx_ff;
   logic [VW:0]     time_ff;
   logic [VW:0]     sp_ff;
   logic [VW:0]     br_total_ff;
   gbf_pkg::frame_type top_ff;
   logic [VW-1:0]   child_low_ff;
   logic [VW-1:0]   child_vtx_ff;
   logic [VW:0]     si_ff;
   logic [VW:0]     sj_ff;
   logic [gbf_pkg::BrW-1:0] key_ff;
   logic [VW:0]     ek_ff;
   gbf_pkg::rsp_type rsp_ff;
   logic            rsp_valid_ff;
   logic [gbf_pkg::MaxVertices-1:0] vis_ff;

   // Memory ports.
   logic                    e_we;
   logic [EA-1:0]           e_wa, e_ra;
   logic [2*VW-1:0]         e_wd, e_rd;
   logic                    s_we;
   logic [VW-1:0]           s_wa, s_ra;
   gbf_pkg::frame_type      s_wd, s_rd;
   logic                    d_we;
   logic [VW-1:0]           d_wa, d_ra;
   logic [VW-1:0]           d_wd, d_rd;
   logic                    l_we;
   logic [VW-1:0]           l_wa, l_ra;
   logic [VW-1:0]           l_wd, l_rd;
   logic                    b_we;
   logic [VW-1:0]           b_wa, b_ra;
   logic [gbf_pkg::BrW-1:0] b_wd, b_rd;

   gbf_ram #(.Width(2*VW), .Depth(gbf_pkg::MaxEdges)) u_edges (
      .clock, .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd), .rd_addr(e_ra),
      .rd_data(e_rd));
   gbf_ram #(.Width(gbf_pkg::FrameW), .Depth(gbf_pkg::MaxVertices)) u_stack (
      .clock, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(s_ra),
      .rd_data(s_rd));
   gbf_ram #(.Width(VW), .Depth(gbf_pkg::MaxVertices)) u_disc (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd), .rd_addr(d_ra),
      .rd_data(d_rd));
   gbf_ram #(.Width(VW), .Depth(gbf_pkg::MaxVertices)) u_low (
      .clock, .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd), .rd_addr(l_ra),
      .rd_data(l_rd));
   gbf_ram #(.Width(gbf_pkg::BrW), .Depth(gbf_pkg::MaxVertices)) u_brlist (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd), .rd_addr(b_ra),
      .rd_data(b_rd));

   // Decoded current edge slot.
   logic [VW-1:0] ea, eb, nbr, self_end;
   logic          in_range, slot_ok, stack_empty_after;
   logic [CW-1:0] slot_lim;
   assign ea       = e_rd[VW-1:0];
   assign eb       = e_rd[2*VW-1:VW];
   assign in_range = ({1'b0, ea} < nvtx_ff) && ({1'b0, eb} < nvtx_ff);
   assign self_end = top_ff.cursor[0] ? eb : ea;
   assign nbr      = top_ff.cursor[0] ? ea : eb;
   assign slot_ok  = in_range && (self_end == top_ff.vtx) &&
                     !(top_ff.has_parent && nbr == top_ff.parent);
   assign slot_lim = {edge_total_ff, 1'b0};
   assign stack_empty_after = (sp_ff == (VW+1)'(1));

   logic [VW:0] nclamp;
   always_comb begin
      nclamp = req_data.vertex_count;
      if (req_data.vertex_count == '0) begin
         nclamp = (VW+1)'(1);
      end else if (req_data.vertex_count > 7'(gbf_pkg::MaxVertices)) begin
         nclamp = (VW+1)'(gbf_pkg::MaxVertices);
      end
   end

   // Memory port control, decoded from the state.
   always_comb begin
      e_we = 1'b0; e_wa = edge_total_ff[EA-1:0]; e_wd = {req_data.end_b, req_data.end_a};
      e_ra = top_ff.cursor[EA:1];
      s_we = 1'b0; s_wa = '0; s_wd = top_ff; s_ra = sp_ff[VW-1:0] - VW'(1);
      d_we = 1'b0; d_wa = '0; d_wd = time_ff[VW-1:0]; d_ra = top_ff.vtx;
      l_we = 1'b0; l_wa = '0; l_wd = time_ff[VW-1:0]; l_ra = top_ff.vtx;
      b_we = 1'b0; b_wa = '0; b_wd = key_ff; b_ra = sj_ff[VW-1:0] - VW'(1);
      unique case (state_ff)
         ST_IDLE: begin
            e_we = req_valid && req_data.opcode == gbf_pkg::OP_ADD &&
                   edge_total_ff < (EA+1)'(gbf_pkg::MaxEdges);
         end
         ST_START: begin
            s_we = 1'b1; s_wa = '0;
            s_wd = '{vtx: '0, parent: '0, has_parent: 1'b0, cursor: '0};
            d_we = 1'b1; d_wd = '0; l_we = 1'b1; l_wd = '0;
         end
         ST_EDGE: begin
            s_wa = sp_ff[VW-1:0] - VW'(1);
            s_we = 1'b1;
            s_wd = top_ff;
            s_wd.cursor = top_ff.cursor + CW'(1);
            l_ra = nbr;
            if (slot_ok && !vis_ff[nbr]) begin
               s_wa = sp_ff[VW-1:0];
               s_wd = '{vtx: nbr, parent: top_ff.vtx, has_parent: 1'b1,
                        cursor: '0};
               d_we = 1'b1; d_wa = nbr; l_we = 1'b1; l_wa = nbr;
            end
         end
         ST_NBR: begin
            if (child_low_ff < l_rd) begin
               l_we = 1'b1; l_wa = top_ff.vtx; l_wd = child_low_ff;
            end
         end
         ST_POP_WAIT: s_ra = sp_ff[VW-1:0] - VW'(2);
         ST_POP_LOAD: begin
            d_ra = s_rd.vtx;
            l_ra = s_rd.vtx;
         end
         ST_POP: begin
            // Here top_ff is the parent, child values are held aside.
            // The parent's cursor still points at the tree edge, so step past it.
            s_we = 1'b1; s_wa = sp_ff[VW-1:0] - VW'(1);
            s_wd = top_ff;
            s_wd.cursor = top_ff.cursor + CW'(1);
            if (child_low_ff < l_rd) begin
               l_we = 1'b1; l_wa = top_ff.vtx; l_wd = child_low_ff;
            end
            if (d_rd < child_low_ff && br_total_ff < (VW+1)'(gbf_pkg::MaxVertices)) begin
               b_we = 1'b1; b_wa = br_total_ff[VW-1:0];
               b_wd = (top_ff.vtx < child_vtx_ff) ? {top_ff.vtx, child_vtx_ff}
                                                  : {child_vtx_ff, top_ff.vtx};
            end
         end
         ST_SORT_I: b_ra = si_ff[VW-1:0];
         ST_SORT_CMP: begin
            if (b_rd > key_ff) begin
               b_we = 1'b1; b_wa = sj_ff[VW-1:0]; b_wd = b_rd;
            end
         end
         ST_SORT_PUT: begin
            b_we = 1'b1; b_wa = sj_ff[VW-1:0]; b_wd = key_ff;
         end
         ST_EMIT_RD: b_ra = ek_ff[VW-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  unique case (req_data.opcode)
                     gbf_pkg::OP_CLEAR: begin
                        edge_total_ff <= '0; overflow_ff <= 1'b0;
                     end
                     gbf_pkg::OP_ADD: begin
                        if (edge_total_ff < (EA+1)'(gbf_pkg::MaxEdges)) begin
                           edge_total_ff <= edge_total_ff + (EA+1)'(1);
                        end else begin
                           overflow_ff <= 1'b1;
                        end
                     end
                     gbf_pkg::OP_RUN: begin
                        nvtx_ff     <= nclamp;
                        state_ff    <= ST_START;
                     end
                     default: ;
                  endcase
               end
            end
            ST_START: begin
               vis_ff      <= {{(gbf_pkg::MaxVertices-1){1'b0}}, 1'b1};
               time_ff     <= (VW+1)'(1);
               sp_ff       <= (VW+1)'(1);
               br_total_ff <= '0;
               state_ff    <= ST_FRAME_RD;
            end
            ST_FRAME_RD: state_ff <= ST_FRAME_WAIT;
            ST_FRAME_WAIT: begin
               top_ff <= s_rd;
               if (s_rd.cursor >= slot_lim) begin
                  child_vtx_ff <= s_rd.vtx;
                  state_ff     <= ST_POP_WAIT;
               end else begin
                  state_ff <= ST_EDGE_WAIT;
               end
            end
            ST_EDGE_WAIT: state_ff <= ST_EDGE;
            ST_EDGE: begin
               if (slot_ok && !vis_ff[nbr]) begin
                  vis_ff[nbr] <= 1'b1;
                  time_ff     <= time_ff + (VW+1)'(1);
                  sp_ff       <= sp_ff + (VW+1)'(1);
                  state_ff    <= ST_FRAME_RD;
               end else if (slot_ok) begin
                  state_ff <= ST_NBR_WAIT;
               end else begin
                  top_ff.cursor <= top_ff.cursor + CW'(1);
                  if (top_ff.cursor + CW'(1) >= slot_lim) begin
                     state_ff <= ST_FRAME_RD;
                  end else begin
                     state_ff <= ST_EDGE_WAIT;
                  end
               end
            end
            ST_NBR_WAIT: begin
               // Low time of the visited neighbor arrives; own low read next.
               child_low_ff <= l_rd;
               state_ff     <= ST_NBR;
            end
            ST_NBR: begin
               top_ff.cursor <= top_ff.cursor + CW'(1);
               state_ff <= ST_FRAME_RD;
            end
            ST_POP_WAIT: begin
               child_low_ff <= l_rd;
               if (stack_empty_after) begin
                  sp_ff    <= '0;
                  si_ff    <= (VW+1)'(1);
                  state_ff <= ST_SORT_I;
               end else begin
                  sp_ff    <= sp_ff - (VW+1)'(1);
                  state_ff <= ST_POP_LOAD;
               end
            end
            ST_POP_LOAD: begin
               top_ff   <= s_rd;
               state_ff <= ST_POP;
            end
            ST_POP: begin
               if (d_rd < child_low_ff &&
                   br_total_ff < (VW+1)'(gbf_pkg::MaxVertices)) begin
                  br_total_ff <= br_total_ff + (VW+1)'(1);
               end
               state_ff <= ST_FRAME_RD;
            end
            ST_SORT_I: begin
               if (si_ff >= br_total_ff) begin
                  ek_ff    <= '0;
                  state_ff <= ST_EMIT_RD;
               end else begin
                  sj_ff    <= si_ff;
                  state_ff <= ST_SORT_KEY;
               end
            end
            ST_SORT_KEY: begin
               key_ff   <= b_rd;
               state_ff <= ST_SORT_CMP_RD;
            end
            ST_SORT_CMP_RD: begin
               state_ff <= (sj_ff == '0) ? ST_SORT_PUT : ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
               if (b_rd > key_ff) begin
                  sj_ff    <= sj_ff - (VW+1)'(1);
                  state_ff <= ST_SORT_CMP_RD;
               end else begin
                  state_ff <= ST_SORT_PUT;
               end
            end
            ST_SORT_PUT: begin
               si_ff    <= si_ff + (VW+1)'(1);
               state_ff <= ST_SORT_I;
            end
            ST_EMIT_RD: state_ff <= ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
               if (br_total_ff == '0) begin
                  rsp_ff <= '{bridge_low: '0, bridge_high: '0, found: 1'b0,
                              last: 1'b1, overflow: overflow_ff};
               end else begin
                  rsp_ff <= '{bridge_low: b_rd[2*VW-1:VW], bridge_high: b_rd[VW-1:0],
                              found: 1'b1,
                              last: (ek_ff + (VW+1)'(1) == br_total_ff),
                              overflow: overflow_ff};
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  ek_ff        <= ek_ff + (VW+1)'(1);
                  state_ff     <= rsp_ff.last ? ST_IDLE : ST_EMIT_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_only_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_EMIT)
      else $error("response valid outside emit");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready during a run");
   a_edges_bound: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= (EA+1)'(gbf_pkg::MaxEdges))
      else $error("edge count beyond store");
`endif

endmodule

// File: sv/gbf_ram.sv
// ============================================================================
// gbf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module gbf_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
